FILE: rtl/msc_pkg.sv
// shared types, codes and constants of the multichannel iir sensor conditioner
// no dependencies; used by every module and interface of the block
package msc_pkg;

  localparam int CH_W     = 2;
  localparam int NUM_CH   = 3;
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 8;
  localparam int ACC_W    = 32;
  localparam int GAIN_W   = 9;
  localparam int PCT_W    = 7;
  localparam int CNT_W    = 8;

  // channel codes
  localparam logic [CH_W-1:0] CH_REFERENCE  = 2'd0;
  localparam logic [CH_W-1:0] CH_THERMISTOR = 2'd1;
  localparam logic [CH_W-1:0] CH_LIGHT      = 2'd2;
  localparam logic [CH_W-1:0] CH_NONE       = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_THERM_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_OFS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_ON     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_OFF    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT     = 3'd6;

  // reset values of the registers
  localparam logic [GAIN_W-1:0] RST_THERM_GAIN = 9'd160;
  localparam logic [GAIN_W-1:0] RST_REF_GAIN   = 9'd160;
  localparam logic [GAIN_W-1:0] RST_LIGHT_GAIN = 9'd4;
  localparam logic [PCT_W-1:0]  RST_LIGHT_OFS  = 7'd20;
  localparam logic [PCT_W-1:0]  RST_LED_ON     = 7'd45;
  localparam logic [PCT_W-1:0]  RST_LED_OFF    = 7'd55;
  localparam logic [CNT_W-1:0]  RST_REPORT     = 8'd4;

  // light scaling: level = (light * 100) >> 10
  localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
  localparam int               LIGHT_SHIFT = 10;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_reference;
    logic [GAIN_W-1:0] gain_thermistor;
    logic [GAIN_W-1:0] gain_light;
  } gains_t;

  typedef struct packed {
    logic [PCT_W-1:0] light_offset;
    logic [PCT_W-1:0] led_on_below;
    logic [PCT_W-1:0] led_off_above;
    logic [CNT_W-1:0] report_every;
  } batch_cfg_t;

  typedef struct packed {
    logic [PCT_W-1:0] light_percent;
    logic             led_on;
    logic             report_due;
  } batch_res_t;

endpackage

FILE: rtl/msc_in_if.sv
// sample input channel: valid/ready handshake with channel tag, sample and batch end
// depends on msc_pkg
interface msc_in_if;
  logic                                valid;
  logic                                ready;
  logic [msc_pkg::CH_W-1:0]            channel;
  logic signed [msc_pkg::SAMPLE_W-1:0] sample;
  logic                                end_of_batch;

  modport source (output valid, channel, sample, end_of_batch, input ready);
  modport sink (input valid, channel, sample, end_of_batch, output ready);
endinterface

FILE: rtl/msc_out_if.sv
// result channel: valid/ready handshake with filtered value and batch evaluation fields
// depends on msc_pkg
interface msc_out_if;
  logic                                valid;
  logic                                ready;
  logic [msc_pkg::CH_W-1:0]            channel_out;
  logic signed [msc_pkg::SAMPLE_W-1:0] filtered_value;
  logic                                batch_done;
  logic [msc_pkg::PCT_W-1:0]           light_percent;
  logic                                led_on;
  logic                                report_due;

  modport source (output valid, channel_out, filtered_value, batch_done, light_percent,
                  led_on, report_due, input ready);
  modport sink (input valid, channel_out, filtered_value, batch_done, light_percent,
                led_on, report_due, output ready);
endinterface

FILE: rtl/msc_filter.sv
// per-channel first-order iir: accumulator memory, first-sample flags, update datapath
// depends on msc_pkg
module msc_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [msc_pkg::CH_W-1:0]            rd_ch_i,
  input  logic                                exec_i,
  input  logic [msc_pkg::CH_W-1:0]            ch_i,
  input  logic signed [msc_pkg::SAMPLE_W-1:0] x_i,
  input  msc_pkg::gains_t                     gains_i,
  output logic signed [msc_pkg::SAMPLE_W-1:0] filt_o
);
  import msc_pkg::*;

  localparam int DIFF_W = ACC_W + 1;
  localparam int DQ_W   = DIFF_W - FRAC_W;
  localparam int PROD_W = DQ_W + GAIN_W + 1;
  localparam int K_W    = ACC_W - FRAC_W + 1;

  logic [ACC_W-1:0]      acc_mem [NUM_CH];
  logic [ACC_W-1:0]      rdata_q;
  logic [NUM_CH-1:0]     pend_q;
  logic [(1<<CH_W)-1:0]  pend_ext;
  logic [CH_W-1:0]       rd_addr;
  logic                  valid_ch;
  logic                  first;
  logic [GAIN_W-1:0]     gain;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DQ_W-1:0]   dq;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]      w;
  logic signed [K_W-1:0] k;
  logic signed [SAMPLE_W-1:0] sat;
  logic [ACC_W-1:0]      load_val;
  logic                  wr_en;
  logic [ACC_W-1:0]      wr_data;

  assign rd_addr  = (rd_ch_i == CH_NONE) ? CH_REFERENCE : rd_ch_i;
  assign valid_ch = (ch_i != CH_NONE);
  assign pend_ext = {{((1<<CH_W)-NUM_CH){1'b0}}, pend_q};
  assign first    = pend_ext[ch_i];

  always_comb begin
    case (ch_i)
      CH_REFERENCE:  gain = gains_i.gain_reference;
      CH_THERMISTOR: gain = gains_i.gain_thermistor;
      default:       gain = gains_i.gain_light;
    endcase
  end

  // acc += floor((x*256 - acc) / 256) * gain, wrapping at 32 bits
  always_comb begin
    diff = $signed({{(DIFF_W-SAMPLE_W-FRAC_W){x_i[SAMPLE_W-1]}}, x_i, {FRAC_W{1'b0}}})
         - $signed({rdata_q[ACC_W-1], rdata_q});
    dq   = diff[DIFF_W-1:FRAC_W];
    prod = $signed({{(PROD_W-DQ_W){dq[DQ_W-1]}}, dq})
         * $signed({{(PROD_W-GAIN_W){1'b0}}, gain});
    w    = rdata_q + prod[ACC_W-1:0];
    k    = $signed({w[ACC_W-1], w[ACC_W-1:FRAC_W]}) + $signed({{(K_W-1){1'b0}}, w[FRAC_W-1]});
    if (k > $signed(K_W'(32767))) begin
      sat = 16'sh7fff;
    end else if (k < -$signed(K_W'(32768))) begin
      sat = -16'sh8000;
    end else begin
      sat = k[SAMPLE_W-1:0];
    end
  end

  assign load_val = {{(ACC_W-SAMPLE_W-FRAC_W){x_i[SAMPLE_W-1]}}, x_i, {FRAC_W{1'b0}}};
  assign wr_en    = exec_i && valid_ch;
  assign wr_data  = first ? load_val : w;

  always_comb begin
    if (!valid_ch) begin
      filt_o = '0;
    end else if (first) begin
      filt_o = x_i;
    end else begin
      filt_o = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= acc_mem[rd_addr];
    end
    if (wr_en) begin
      acc_mem[ch_i] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '1;
    end else begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (exec_i && ch_i == CH_W'(i)) begin
          pend_q[i] <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/msc_batch.sv
// end-of-batch evaluation: light percent, led hysteresis, report counter
// depends on msc_pkg
module msc_batch (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                light_wr_i,
  input  logic signed [msc_pkg::SAMPLE_W-1:0] light_i,
  input  logic                                commit_i,
  input  logic                                eob_i,
  input  msc_pkg::batch_cfg_t                 cfg_i,
  output msc_pkg::batch_res_t                 res_o
);
  import msc_pkg::*;

  localparam int MAG_W = SAMPLE_W - 1;
  localparam int SCL_W = MAG_W + PCT_W;
  localparam int LVL_W = SCL_W - LIGHT_SHIFT;
  localparam int DL_W  = LVL_W + 1;

  logic signed [SAMPLE_W-1:0] latest_q;
  logic                       led_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [MAG_W-1:0]           mag;
  logic [SCL_W-1:0]           scaled;
  logic [LVL_W-1:0]           lvl;
  logic [DL_W-1:0]            dl;
  logic [PCT_W-1:0]           pct;
  logic                       led_d;
  logic                       report;

  always_comb begin
    mag    = latest_q[SAMPLE_W-1] ? '0 : latest_q[MAG_W-1:0];
    scaled = SCL_W'(mag) * SCL_W'(PCT_MAX);
    lvl    = scaled[SCL_W-1:LIGHT_SHIFT];
    dl     = DL_W'(lvl) - DL_W'(cfg_i.light_offset);
    if (DL_W'(lvl) < DL_W'(cfg_i.light_offset)) begin
      pct = '0;
    end else if (dl > DL_W'(PCT_MAX)) begin
      pct = PCT_MAX;
    end else begin
      pct = dl[PCT_W-1:0];
    end
    // on test wins over off test
    if (!eob_i) begin
      led_d = led_q;
    end else if (pct < cfg_i.led_on_below) begin
      led_d = 1'b1;
    end else if (pct > cfg_i.led_off_above) begin
      led_d = 1'b0;
    end else begin
      led_d = led_q;
    end
    report = eob_i && (cnt_q == cfg_i.report_every);
  end

  assign res_o.light_percent = eob_i ? pct : '0;
  assign res_o.led_on        = led_d;
  assign res_o.report_due    = report;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= '0;
      led_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (light_wr_i) begin
        latest_q <= light_i;
      end
      if (commit_i && eob_i) begin
        led_q <= led_d;
        cnt_q <= report ? '0 : cnt_q + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/multichannel_iir_sensor_conditioner.sv
// three-channel iir sensor conditioner: top level with sequencer, register file, result register
// depends on msc_pkg, msc_in_if, msc_out_if, msc_filter, msc_batch
//
// Each input beat carries one ADC sample tagged with its channel (reference, thermistor,
// light). The channel's first sample loads its accumulator and is passed through; later
// samples run the first-order iir update with that channel's gain and return the value
// rounded on bit 7, saturated to 16 bits. A beat flagged end_of_batch also evaluates the
// latest filtered light value into a 0..100 percent, steps the led hysteresis and the
// report counter. An item goes through three steps: the read of the accumulator memory,
// the multiply and write-back, and the batch evaluation into the result register. The
// next beat is taken in the evaluation step once the result register is free, paced by
// the read/modify/write of the accumulator memory: the next beat's read is
// only issued once this beat's write-back has landed. Every input beat gives exactly one
// result beat; a result waits in the output register while the block goes on.
// Configuration writes belong to idle periods; there is no read-back.
module multichannel_iir_sensor_conditioner (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  msc_in_if.sink                           in_s,
  msc_out_if.source                        out_m,
  input  logic                             cfg_we_i,
  input  logic [msc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [msc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import msc_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILT = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [CH_W-1:0]            ch_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       eob_q;
  logic signed [SAMPLE_W-1:0] filt_q;
  logic signed [SAMPLE_W-1:0] filt;
  gains_t                     gains_q;
  batch_cfg_t                 bcfg_q;
  batch_res_t                 bres;
  logic                       accept;
  logic                       load_ok;
  logic                       out_load;
  logic                       exec;

  // output register
  logic                       out_vld_q;
  logic [CH_W-1:0]            out_ch_q;
  logic signed [SAMPLE_W-1:0] out_val_q;
  logic                       out_eob_q;
  batch_res_t                 out_res_q;

  // result register frees up when empty or drained this cycle
  assign load_ok  = !out_vld_q || out_m.ready;
  assign out_load = (state_q == ST_EVAL) && load_ok;
  assign exec     = (state_q == ST_FILT);
  assign in_s.ready = (state_q == ST_IDLE) || out_load;
  assign accept   = in_s.valid && in_s.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_FILT;
      end
      ST_FILT: state_d = ST_EVAL;
      ST_EVAL: begin
        if (out_load) state_d = accept ? ST_FILT : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_m.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // item payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= in_s.channel;
      x_q   <= in_s.sample;
      eob_q <= in_s.end_of_batch;
    end
    if (exec) begin
      filt_q <= filt;
    end
    if (out_load) begin
      out_ch_q  <= ch_q;
      out_val_q <= filt_q;
      out_eob_q <= eob_q;
      out_res_q <= bres;
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.gain_thermistor <= RST_THERM_GAIN;
      gains_q.gain_reference  <= RST_REF_GAIN;
      gains_q.gain_light      <= RST_LIGHT_GAIN;
      bcfg_q.light_offset     <= RST_LIGHT_OFS;
      bcfg_q.led_on_below     <= RST_LED_ON;
      bcfg_q.led_off_above    <= RST_LED_OFF;
      bcfg_q.report_every     <= RST_REPORT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THERM_GAIN: gains_q.gain_thermistor <= cfg_wdata_i[GAIN_W-1:0];
        CFG_REF_GAIN:   gains_q.gain_reference  <= cfg_wdata_i[GAIN_W-1:0];
        CFG_LIGHT_GAIN: gains_q.gain_light      <= cfg_wdata_i[GAIN_W-1:0];
        CFG_LIGHT_OFS:  bcfg_q.light_offset     <= cfg_wdata_i[PCT_W-1:0];
        CFG_LED_ON:     bcfg_q.led_on_below     <= cfg_wdata_i[PCT_W-1:0];
        CFG_LED_OFF:    bcfg_q.led_off_above    <= cfg_wdata_i[PCT_W-1:0];
        CFG_REPORT:     bcfg_q.report_every     <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulator read is issued on the accepting edge, write-back in the filter cycle
  msc_filter u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .rd_ch_i (in_s.channel),
    .exec_i  (exec),
    .ch_i    (ch_q),
    .x_i     (x_q),
    .gains_i (gains_q),
    .filt_o  (filt)
  );

  // latest light value is updated in the filter cycle, ahead of this item's evaluation
  msc_batch u_batch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .light_wr_i (exec && (ch_q == CH_LIGHT)),
    .light_i    (filt),
    .commit_i   (out_load),
    .eob_i      (eob_q),
    .cfg_i      (bcfg_q),
    .res_o      (bres)
  );

  assign out_m.valid          = out_vld_q;
  assign out_m.channel_out    = out_ch_q;
  assign out_m.filtered_value = out_val_q;
  assign out_m.batch_done     = out_eob_q;
  assign out_m.light_percent  = out_res_q.light_percent;
  assign out_m.led_on         = out_res_q.led_on;
  assign out_m.report_due     = out_res_q.report_due;

endmodule

FILE: bench/multichannel_iir_sensor_conditioner_tb.sv
// testbench of the multichannel iir sensor conditioner: directed table, then random batches
// depends on msc_pkg, msc_in_if, msc_out_if and the block's top level
`timescale 1ns / 1ps

module multichannel_iir_sensor_conditioner_tb;
  import msc_pkg::*;

  // one sample beat as it goes into the block
  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                eob;
  } sample_beat_t;

  // one conditioned beat as it leaves the block
  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] filtered;
    logic                batch_done;
    logic [PCT_W-1:0]    pct;
    logic                led;
    logic                report;
  } conditioned_t;

  // directed row: the beat, and a hand-written result where one is given
  typedef struct packed {
    sample_beat_t beat;
    logic         typed;
    conditioned_t res;
  } script_row_t;

  localparam conditioned_t NO_RES       = '0;
  localparam int           SCRIPT_LEN   = 21;
  localparam int           PHASES       = 8;
  localparam int           PHASE_ITEMS  = 150;
  localparam int           QUIET_LIMIT  = 1000;
  localparam int           SETTLE       = 8;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  msc_in_if  smp_if ();
  msc_out_if cond_if ();

  multichannel_iir_sensor_conditioner DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (smp_if),
    .out_m       (cond_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor copy of the registers
  logic [GAIN_W-1:0] therm_gain_r;
  logic [GAIN_W-1:0] ref_gain_r;
  logic [GAIN_W-1:0] light_gain_r;
  logic [PCT_W-1:0]  light_ofs_r;
  logic [PCT_W-1:0]  on_below_r;
  logic [PCT_W-1:0]  off_above_r;
  logic [CNT_W-1:0]  report_every_r;

  // predictor copy of the filter and batch state
  logic [ACC_W-1:0]           acc_m [NUM_CH];
  logic                       first_m [NUM_CH];
  logic signed [SAMPLE_W-1:0] light_latest;
  logic                       led_m;
  logic [CNT_W-1:0]           batch_cnt;

  conditioned_t conditioned_q [$];
  int           errors;
  int           quiet_cycles;
  logic         steady;

  // directed part: after-reset and extreme rows are typed in, the rest go to the predictor
  script_row_t script [SCRIPT_LEN] = '{
    // channel three with batch end before any light sample: light reads as zero, led on
    '{'{CH_NONE,       16'h7fff, 1'b1}, 1'b1, '{CH_NONE, 16'h0000, 1'b1, 7'd0, 1'b1, 1'b0}},
    '{'{CH_NONE,       16'h8000, 1'b0}, 1'b1, '{CH_NONE, 16'h0000, 1'b0, 7'd0, 1'b1, 1'b0}},
    // first sample of each channel passes straight through
    '{'{CH_REFERENCE,  16'h7fff, 1'b0}, 1'b1,
      '{CH_REFERENCE, 16'h7fff, 1'b0, 7'd0, 1'b1, 1'b0}},
    '{'{CH_THERMISTOR, 16'h8000, 1'b0}, 1'b1,
      '{CH_THERMISTOR, 16'h8000, 1'b0, 7'd0, 1'b1, 1'b0}},
    // full-scale light saturates the percent at 100 and turns the led off
    '{'{CH_LIGHT,      16'h7fff, 1'b1}, 1'b1, '{CH_LIGHT, 16'h7fff, 1'b1, 7'd100, 1'b0, 1'b0}},
    // full swings from one extreme to the other
    '{'{CH_REFERENCE,  16'h8000, 1'b0}, 1'b0, NO_RES},
    '{'{CH_THERMISTOR, 16'h7fff, 1'b0}, 1'b0, NO_RES},
    '{'{CH_LIGHT,      16'h8000, 1'b1}, 1'b0, NO_RES},
    '{'{CH_LIGHT,      16'h0000, 1'b0}, 1'b0, NO_RES},
    '{'{CH_LIGHT,      16'h0000, 1'b1}, 1'b0, NO_RES},
    // counter meets report_every here
    '{'{CH_NONE,       16'h0000, 1'b1}, 1'b0, NO_RES},
    '{'{CH_REFERENCE,  16'h0001, 1'b0}, 1'b0, NO_RES},
    '{'{CH_REFERENCE,  16'hffff, 1'b0}, 1'b0, NO_RES},
    '{'{CH_THERMISTOR, 16'h5555, 1'b0}, 1'b0, NO_RES},
    '{'{CH_THERMISTOR, 16'haaaa, 1'b1}, 1'b0, NO_RES},
    '{'{CH_LIGHT,      16'd500,  1'b0}, 1'b0, NO_RES},
    '{'{CH_LIGHT,      16'd600,  1'b1}, 1'b0, NO_RES},
    '{'{CH_LIGHT,      16'd700,  1'b1}, 1'b0, NO_RES},
    '{'{CH_LIGHT,      16'd800,  1'b1}, 1'b0, NO_RES},
    '{'{CH_REFERENCE,  16'h0000, 1'b1}, 1'b0, NO_RES},
    '{'{CH_THERMISTOR, 16'h0000, 1'b1}, 1'b0, NO_RES}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // works out the conditioned beat for one sample and advances the predictor state
  function automatic conditioned_t condition_sample(input sample_beat_t b);
    conditioned_t       r;
    logic signed [63:0] x;
    logic signed [63:0] acc;
    logic signed [63:0] diff;
    logic signed [63:0] nxt;
    logic signed [63:0] wext;
    logic signed [63:0] k;
    logic signed [63:0] gain64;
    logic [ACC_W-1:0]   w;
    logic [GAIN_W-1:0]  gain;
    logic signed [SAMPLE_W-1:0] filt;
    int                 lvl;
    int                 lit;
    r = NO_RES;
    r.channel = b.channel;
    r.batch_done = b.eob;
    filt = '0;
    x = {{48{b.sample[SAMPLE_W-1]}}, b.sample};
    if (b.channel != CH_NONE) begin
      if (first_m[b.channel]) begin
        // first sample loads the accumulator with 8 fraction bits
        acc_m[b.channel] = ACC_W'(x <<< FRAC_W);
        first_m[b.channel] = 1'b0;
        filt = b.sample;
      end else begin
        case (b.channel)
          CH_REFERENCE:  gain = ref_gain_r;
          CH_THERMISTOR: gain = therm_gain_r;
          default:       gain = light_gain_r;
        endcase
        gain64 = {55'd0, gain};
        acc = {{32{acc_m[b.channel][ACC_W-1]}}, acc_m[b.channel]};
        diff = (x <<< FRAC_W) - acc;
        // arithmetic shift floors toward minus infinity; the sum wraps at 32 bits
        nxt = acc + (diff >>> FRAC_W) * gain64;
        w = nxt[ACC_W-1:0];
        acc_m[b.channel] = w;
        wext = {{32{w[ACC_W-1]}}, w};
        k = (wext >>> FRAC_W) + (w[FRAC_W-1] ? 64'sd1 : 64'sd0);
        if (k > 64'sd32767)
          filt = 16'sh7fff;
        else if (k < -64'sd32768)
          filt = 16'sh8000;
        else
          filt = k[SAMPLE_W-1:0];
      end
      if (b.channel == CH_LIGHT)
        light_latest = filt;
    end
    r.filtered = filt;
    if (b.eob) begin
      lit = light_latest;
      if (lit < 0)
        lit = 0;
      lvl = ((lit * 100) >>> LIGHT_SHIFT) - int'(light_ofs_r);
      if (lvl > 100)
        lvl = 100;
      if (lvl < 0)
        lvl = 0;
      r.pct = PCT_W'(lvl);
      // turning on wins over turning off
      if (lvl < int'(on_below_r))
        led_m = 1'b1;
      else if (lvl > int'(off_above_r))
        led_m = 1'b0;
      if (batch_cnt == report_every_r) begin
        r.report = 1'b1;
        batch_cnt = '0;
      end else begin
        batch_cnt = batch_cnt + 1'b1;
      end
    end
    r.led = led_m;
    return r;
  endfunction

  // presents one beat, waits for it to be taken, then files its expected result
  task automatic send_sample(input sample_beat_t b, input logic typed, input conditioned_t res);
    conditioned_t r;
    while (!steady && $urandom_range(99) < 8) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid        <= 1'b1;
    smp_if.channel      <= b.channel;
    smp_if.sample       <= b.sample;
    smp_if.end_of_batch <= b.eob;
    @(posedge clk_i);
    while (!smp_if.ready)
      @(posedge clk_i);
    r = condition_sample(b);
    conditioned_q.push_back(typed ? res : r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_THERM_GAIN: therm_gain_r   = val[GAIN_W-1:0];
      CFG_REF_GAIN:   ref_gain_r     = val[GAIN_W-1:0];
      CFG_LIGHT_GAIN: light_gain_r   = val[GAIN_W-1:0];
      CFG_LIGHT_OFS:  light_ofs_r    = val[PCT_W-1:0];
      CFG_LED_ON:     on_below_r     = val[PCT_W-1:0];
      CFG_LED_OFF:    off_above_r    = val[PCT_W-1:0];
      CFG_REPORT:     report_every_r = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // waits for the block to drain, then writes all seven registers
  task automatic program_settings(input logic [GAIN_W-1:0] g_ref, input logic [GAIN_W-1:0] g_th,
                                  input logic [GAIN_W-1:0] g_li, input logic [PCT_W-1:0] ofs,
                                  input logic [PCT_W-1:0] on_b, input logic [PCT_W-1:0] off_a,
                                  input logic [CNT_W-1:0] rep);
    while (conditioned_q.size() != 0)
      @(posedge clk_i);
    write_reg(CFG_THERM_GAIN, g_th);
    write_reg(CFG_REF_GAIN, g_ref);
    write_reg(CFG_LIGHT_GAIN, g_li);
    write_reg(CFG_LIGHT_OFS, ofs);
    write_reg(CFG_LED_ON, on_b);
    write_reg(CFG_LED_OFF, off_a);
    write_reg(CFG_REPORT, rep);
    cfg_we_i <= 1'b0;
  endtask

  // mostly in range, now and then past 256 so the accumulator wraps
  function automatic logic [GAIN_W-1:0] pick_gain();
    if ($urandom_range(9) == 0)
      return GAIN_W'($urandom_range(257, 511));
    return GAIN_W'($urandom_range(0, 256));
  endfunction

  // stimulus
  initial begin
    sample_beat_t b;
    int           sent;
    int           blen;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_wdata_i         = '0;
    smp_if.valid        = 1'b0;
    smp_if.channel      = '0;
    smp_if.sample       = '0;
    smp_if.end_of_batch = 1'b0;
    steady              = 1'b0;
    errors              = 0;
    therm_gain_r        = RST_THERM_GAIN;
    ref_gain_r          = RST_REF_GAIN;
    light_gain_r        = RST_LIGHT_GAIN;
    light_ofs_r         = RST_LIGHT_OFS;
    on_below_r          = RST_LED_ON;
    off_above_r         = RST_LED_OFF;
    report_every_r      = RST_REPORT;
    for (int c = 0; c < NUM_CH; c++) begin
      acc_m[c]   = '0;
      first_m[c] = 1'b1;
    end
    light_latest = '0;
    led_m        = 1'b0;
    batch_cnt    = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under reset settings
    for (int i = 0; i < SCRIPT_LEN; i++)
      send_sample(script[i].beat, script[i].typed, script[i].res);
    smp_if.valid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_settings(9'd0, 9'd0, 9'd0, 7'd0, 7'd0, 7'd0, 8'd0);
        1: program_settings(9'd511, 9'd511, 9'd511, 7'd127, 7'd127, 7'd127, 8'd255);
        2: program_settings(9'd256, 9'd256, 9'd256, PCT_MAX, PCT_MAX, PCT_MAX, 8'd255);
        default: begin
          program_settings(pick_gain(), pick_gain(), pick_gain(),
                           ($urandom_range(4) == 0) ? PCT_W'($urandom_range(0, 127))
                                                    : PCT_W'($urandom_range(0, 40)),
                           PCT_W'($urandom_range(0, 110)), PCT_W'($urandom_range(0, 110)),
                           ($urandom_range(4) == 0) ? CNT_W'($urandom_range(0, 255))
                                                    : CNT_W'($urandom_range(0, 9)));
        end
      endcase
      // one phase runs back to back on both sides
      steady <= (phase == 3);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // a batch of a few samples closed by end_of_batch, now and then broken
        blen = $urandom_range(1, 6);
        for (int j = 0; j < blen; j++) begin
          if ($urandom_range(19) == 0)
            b.channel = CH_NONE;
          else
            b.channel = CH_W'($urandom_range(0, 2));
          case ($urandom_range(9))
            0, 1, 2, 3: b.sample = SAMPLE_W'($urandom);
            4, 5, 6, 7: b.sample = SAMPLE_W'($urandom_range(0, 1400));
            8: begin
              case ($urandom_range(3))
                0: b.sample = 16'h7fff;
                1: b.sample = 16'h8000;
                2: b.sample = 16'h0000;
                default: b.sample = 16'hffff;
              endcase
            end
            default: b.sample = SAMPLE_W'($urandom_range(0, 8)) - 16'd4;
          endcase
          b.eob = (j == blen - 1);
          if ($urandom_range(19) == 0)
            b.eob = ~b.eob;
          send_sample(b, 1'b0, NO_RES);
          sent++;
        end
      end
      smp_if.valid <= 1'b0;
    end

    // drain, then let the pipeline settle so that any stray beat shows
    steady <= 1'b0;
    while (conditioned_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_if.ready <= 1'b0;
    end else begin
      cond_if.ready <= steady || ($urandom_range(99) >= 8);
    end
  end

  // compare every result beat with the oldest expectation
  always @(posedge clk_i) begin
    conditioned_t e;
    if (rst_ni && cond_if.valid && cond_if.ready) begin
      if (conditioned_q.size() == 0) begin
        $error("unexpected result beat: channel_out %0d", cond_if.channel_out);
        errors++;
      end else begin
        e = conditioned_q.pop_front();
        if (cond_if.channel_out !== e.channel) begin
          $error("channel_out: expected %0d, got %0d", e.channel, cond_if.channel_out);
          errors++;
        end
        if (cond_if.filtered_value !== e.filtered) begin
          $error("filtered_value: expected %0d, got %0d", $signed(e.filtered),
                 cond_if.filtered_value);
          errors++;
        end
        if (cond_if.batch_done !== e.batch_done) begin
          $error("batch_done: expected %0d, got %0d", e.batch_done, cond_if.batch_done);
          errors++;
        end
        if (cond_if.light_percent !== e.pct) begin
          $error("light_percent: expected %0d, got %0d", e.pct, cond_if.light_percent);
          errors++;
        end
        if (cond_if.led_on !== e.led) begin
          $error("led_on: expected %0d, got %0d", e.led, cond_if.led_on);
          errors++;
        end
        if (cond_if.report_due !== e.report) begin
          $error("report_due: expected %0d, got %0d", e.report, cond_if.report_due);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without a beat on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (cond_if.valid && cond_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
